// ----- rtl/rit_pkg.sv -----
package rit_pkg;

  // Operation carried on the input tuser bit
  typedef enum logic {
    OP_ARM  = 1'b0,
    OP_POLL = 1'b1
  } rit_op_t;

  // Configuration register indexes
  typedef enum logic {
    REG_INTERVAL = 1'b0,
    REG_REPEAT   = 1'b1
  } rit_reg_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD,
    ST_RESULT
  } rit_state_t;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned STEP_W   = 5;

  localparam logic [COUNT_W-1:0] ENDLESS_CODE   = 16'hFFFF;
  localparam logic [TIME_W-1:0]  INTERVAL_RESET = 32'd100;
  localparam logic [STEP_W-1:0]  LAST_STEP      = 5'd31;

endpackage

// ----- rtl/repeating_interval_timer_core.sv -----
// Periodic timer with a repeat count. Configure interval_us (index 0) and
// repeat_count (index 1, 65535 = endless) while idle, then send an arm beat
// (tuser = 0) with the current microsecond time: the period is latched,
// clamped up to MIN_INTERVAL, and the deadline is set one period ahead.
// Poll beats (tuser = 1) return how many periods have elapsed once the
// deadline is reached (wrap-around compare of 32-bit times), advance the
// deadline by that many periods and consume one firing (none when the count
// is endless). Every input beat gives exactly one output beat. An arm, an
// idle poll or a poll before the deadline goes from acceptance through the
// result state into the result register. A due poll first passes the
// 32-step restoring divider: it forms overshoot / period one quotient bit
// per cycle in a single shared subtractor, followed by the update state and
// the result state, which holds while the output register is still full.
// One beat is in flight at a time; the next is accepted as soon as the
// result has moved to the output register, even while that register still
// waits for out_tready.
module repeating_interval_timer_core
  import rit_pkg::*;
#(
  parameter int unsigned MIN_INTERVAL = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] now_us
  input  logic        in_tuser,   // [0] op
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] intervals_passed, [32] active, [39:33] zero
);

  localparam logic [TIME_W-1:0] MinInterval = TIME_W'(MIN_INTERVAL);

  rit_state_t          state_r, state_nxt;

  // configuration registers
  logic [TIME_W-1:0]   interval_r, interval_nxt;
  logic [COUNT_W-1:0]  repeat_r, repeat_nxt;

  // timer state
  logic [TIME_W-1:0]   next_due_r, next_due_nxt;
  logic [COUNT_W-1:0]  firings_r, firings_nxt;
  logic [TIME_W-1:0]   period_r, period_nxt;

  // divider working registers
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [TIME_W-1:0]   quo_r, quo_nxt;
  logic [TIME_W-1:0]   rem_r, rem_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [TIME_W-1:0]   pend_passed_r, pend_passed_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0]   out_passed_r, out_passed_nxt;
  logic                out_active_r, out_active_nxt;

  logic                in_beat;
  logic [TIME_W-1:0]   now_in;
  logic [TIME_W-1:0]   clamped;
  logic [TIME_W-1:0]   diff;
  logic                due;
  logic [TIME_W:0]     shifted;
  logic [TIME_W+1:0]   trial;

  assign in_tready = (state_r == ST_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign now_in    = in_tdata[TIME_W-1:0];

  assign clamped = (interval_r < MinInterval) ? MinInterval : interval_r;

  // Deadline reached when next_due - now is zero or negative as a signed value
  assign diff = next_due_r - now_in;
  assign due  = (diff == '0) || diff[TIME_W-1];

  // Shared subtractor: one restoring-division step
  assign shifted = {rem_r, quo_r[TIME_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, period_r};

  always_comb begin
    state_nxt       = state_r;
    interval_nxt    = interval_r;
    repeat_nxt      = repeat_r;
    next_due_nxt    = next_due_r;
    firings_nxt     = firings_r;
    period_nxt      = period_r;
    now_nxt         = now_r;
    quo_nxt         = quo_r;
    rem_nxt         = rem_r;
    step_nxt        = step_r;
    pend_passed_nxt = pend_passed_r;
    out_valid_nxt   = out_valid_r;
    out_passed_nxt  = out_passed_r;
    out_active_nxt  = out_active_r;

    // drop the output beat once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (rit_reg_t'(cfg_index))
        REG_INTERVAL: interval_nxt = cfg_wdata;
        REG_REPEAT:   repeat_nxt   = cfg_wdata[COUNT_W-1:0];
        default:      ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          now_nxt         = now_in;
          pend_passed_nxt = '0;
          state_nxt       = ST_RESULT;
          if (rit_op_t'(in_tuser) == OP_ARM) begin
            period_nxt   = clamped;
            firings_nxt  = repeat_r;
            next_due_nxt = now_in + clamped;
          end else if ((firings_r != '0) && due) begin
            // overshoot = -diff, at most 2^31; divide it by the period
            quo_nxt   = '0 - diff;
            rem_nxt   = '0;
            step_nxt  = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (trial[TIME_W+1]) begin
          rem_nxt = shifted[TIME_W-1:0];
        end else begin
          rem_nxt = trial[TIME_W-1:0];
        end
        quo_nxt  = {quo_r[TIME_W-2:0], ~trial[TIME_W+1]};
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        // next_due + period * (q + 1) = now + period - remainder
        pend_passed_nxt = quo_r + 1'b1;
        next_due_nxt    = now_r + (period_r - rem_r);
        if (firings_r != ENDLESS_CODE) begin
          firings_nxt = firings_r - 1'b1;
        end
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_passed_nxt = pend_passed_r;
          out_active_nxt = (firings_r != '0);
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      interval_r  <= INTERVAL_RESET;
      repeat_r    <= '0;
      next_due_r  <= '0;
      firings_r   <= '0;
      period_r    <= MinInterval;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      interval_r  <= interval_nxt;
      repeat_r    <= repeat_nxt;
      next_due_r  <= next_due_nxt;
      firings_r   <= firings_nxt;
      period_r    <= period_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r         <= now_nxt;
    quo_r         <= quo_nxt;
    rem_r         <= rem_nxt;
    pend_passed_r <= pend_passed_nxt;
    out_passed_r  <= out_passed_nxt;
    out_active_r  <= out_active_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_active_r, out_passed_r};

`ifndef SYNTHESIS
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && (step_r == LAST_STEP) |=> (state_r == ST_UPD))
    else $error("divider did not finish after its last step");

  a_period_min: assert property (@(posedge clk) disable iff (!rst_n)
    period_r >= MinInterval)
    else $error("latched period below minimum");

  a_rem_lt_period: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> (rem_r < period_r))
    else $error("division remainder not below period");

  a_arm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_tuser == OP_ARM) |=> (state_r == ST_RESULT) && (pend_passed_r == '0))
    else $error("arm beat must report zero intervals");
`endif

endmodule
